FILE: hw/rtl/emau_pkg.sv
`timescale 1ns / 1ps

package emau_pkg;

    // store geometry
    localparam int PAGE_BYTES     = 4096;
    localparam int MEM_ADDR_BITS  = 16;
    localparam int WORD_ADDR_BITS = MEM_ADDR_BITS - 3;
    localparam int WORD_COUNT     = 1 << WORD_ADDR_BITS;
    localparam int WORD_BITS      = 64;

    localparam logic [31:0] PAGE_LIMIT = 32'(PAGE_BYTES);
    localparam logic [32:0] MEM_BYTES  = 33'(64'(1) << MEM_ADDR_BITS);

    // stream packing
    localparam int S_TDATA_BITS = 104;
    localparam int M_TDATA_BITS = 64;

    // front to back queue
    localparam int QUEUE_DEPTH      = 2;
    localparam int QUEUE_PTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef logic [WORD_ADDR_BITS-1:0] word_idx_t;

    // classified request as queued between front and back
    typedef struct packed {
        logic                 is_write;
        logic                 fault;
        logic [1:0]           size;
        word_idx_t            word_idx;
        logic [2:0]           offset;
        logic [WORD_BITS-1:0] wdata;
    } req_t;

    // byte count of an access, 1..8
    function automatic logic [3:0] size_bytes(input logic [1:0] size);
        return 4'd1 << size;
    endfunction

endpackage

FILE: hw/rtl/emau_ram.sv
`timescale 1ns / 1ps

module emau_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/emau_front.sv
`timescale 1ns / 1ps

module emau_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic                                s_tuser,
    input  logic [emau_pkg::S_TDATA_BITS-1:0]   s_tdata,
    output logic                                q_valid,
    output emau_pkg::req_t                      q_req,
    input  logic                                q_pop
);

    logic [1:0]     in_size;
    logic [31:0]    in_addr;
    logic [32:0]    end_addr;
    emau_pkg::req_t in_req;

    emau_pkg::req_t                                entries_reg [emau_pkg::QUEUE_DEPTH];
    logic [emau_pkg::QUEUE_PTR_BITS-1:0]           wr_ptr_reg, wr_ptr_next;
    logic [emau_pkg::QUEUE_PTR_BITS-1:0]           rd_ptr_reg, rd_ptr_next;
    logic [emau_pkg::QUEUE_COUNT_BITS-1:0]         count_reg, count_next;
    logic                                          push, pop;

    // classify: null page / past-end check, word split
    assign in_size  = s_tdata[1:0];
    assign in_addr  = s_tdata[33:2];
    assign end_addr = {1'b0, in_addr} + 33'(emau_pkg::size_bytes(in_size));

    always_comb begin
        in_req.is_write = (s_tuser == emau_pkg::CMD_WRITE);
        in_req.fault    = (in_addr < emau_pkg::PAGE_LIMIT) || (end_addr > emau_pkg::MEM_BYTES);
        in_req.size     = in_size;
        in_req.word_idx = in_addr[emau_pkg::MEM_ADDR_BITS-1:3];
        in_req.offset   = in_addr[2:0];
        in_req.wdata    = s_tdata[97:34];
    end

    assign s_tready = (count_reg != emau_pkg::QUEUE_COUNT_BITS'(emau_pkg::QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_req    = entries_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == emau_pkg::QUEUE_PTR_BITS'(emau_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == emau_pkg::QUEUE_PTR_BITS'(emau_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= in_req;
        end
    end

endmodule

FILE: hw/rtl/emau_back.sv
`timescale 1ns / 1ps

module emau_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                q_valid,
    input  emau_pkg::req_t                      q_req,
    output logic                                q_pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic                                m_tuser,
    output logic [emau_pkg::M_TDATA_BITS-1:0]   m_tdata
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_RD1   = 5'b00010,
        ST_MERGE = 5'b00100,
        ST_WR1   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    emau_pkg::req_t                   req_reg, req_next;
    logic [emau_pkg::WORD_BITS-1:0]   lo_reg, lo_next;
    logic [emau_pkg::WORD_BITS-1:0]   hi_reg, hi_next;
    logic [emau_pkg::WORD_BITS-1:0]   res_reg, res_next;
    logic                             m_tvalid_reg, m_tvalid_next;
    logic                             m_tuser_reg, m_tuser_next;
    logic [emau_pkg::WORD_BITS-1:0]   m_tdata_reg, m_tdata_next;

    logic                             ram_we;
    emau_pkg::word_idx_t              ram_waddr, ram_raddr, next_idx;
    logic [emau_pkg::WORD_BITS-1:0]   ram_wdata, ram_rdata;

    logic [127:0]                     pair, shifted, wide_data, wide_mask, merged;
    logic [6:0]                       shamt;
    logic [7:0]                       byte_mask;
    logic [emau_pkg::WORD_BITS-1:0]   bit_mask;
    logic                             straddle;
    logic                             out_free;

    emau_ram #(
        .WIDTH(emau_pkg::WORD_BITS),
        .DEPTH(emau_pkg::WORD_COUNT)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign next_idx = req_reg.word_idx + 1'b1;

    // two-word window, low word from first read, high word straight off the RAM
    assign pair     = {ram_rdata, lo_reg};
    assign shamt    = {1'b0, req_reg.offset, 3'b000};
    assign straddle = ({1'b0, req_reg.offset} + emau_pkg::size_bytes(req_reg.size)) > 4'd8;

    always_comb begin
        byte_mask = ~(8'hFF << emau_pkg::size_bytes(req_reg.size));
        for (int b = 0; b < 8; b++) begin
            bit_mask[8*b +: 8] = {8{byte_mask[b]}};
        end
    end

    assign shifted   = pair >> shamt;
    assign wide_data = {64'd0, req_reg.wdata & bit_mask} << shamt;
    assign wide_mask = {64'd0, bit_mask} << shamt;
    assign merged    = (pair & ~wide_mask) | (wide_data & wide_mask);

    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        req_next      = req_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        res_next      = res_reg;
        m_tvalid_next = m_tready ? 1'b0 : m_tvalid_reg;
        m_tuser_next  = m_tuser_reg;
        m_tdata_next  = m_tdata_reg;
        q_pop         = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = req_reg.word_idx;
        ram_wdata     = merged[63:0];
        ram_raddr     = next_idx;

        unique case (state_reg)
            ST_IDLE: begin
                ram_raddr = q_req.word_idx;
                if (q_valid) begin
                    q_pop    = 1'b1;
                    req_next = q_req;
                    res_next = '0;
                    state_next = q_req.fault ? ST_OUT : ST_RD1;
                end
            end
            ST_RD1: begin
                lo_next    = ram_rdata;
                state_next = ST_MERGE;
            end
            ST_MERGE: begin
                if (req_reg.is_write) begin
                    ram_we     = 1'b1;
                    hi_next    = merged[127:64];
                    res_next   = '0;
                    state_next = straddle ? ST_WR1 : ST_OUT;
                end else begin
                    res_next   = shifted[63:0] & bit_mask;
                    state_next = ST_OUT;
                end
            end
            ST_WR1: begin
                ram_we     = 1'b1;
                ram_waddr  = next_idx;
                ram_wdata  = hi_reg;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_reg;
                    m_tuser_next  = req_reg.fault;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg     <= req_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        res_reg     <= res_next;
        m_tuser_reg <= m_tuser_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: hw/rtl/emulated_memory_access_unit_top.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  tuser: cmd; tdata: access_size, address, write_data
// m_        out  m_tvalid/m_tready  tuser: fault; tdata: read_data
//
// The back end serves one request at a time: a fault goes straight to the output;
// other requests read both words through the single read port of the word store,
// and a write writes back each word it touches through the single write port.
// Reset (aresetn low, synchronous) empties the queue and output register;
// the store contents are not cleared. Front and back stall independently
// through a two-entry queue; the result register frees as soon as m_tready.

module emulated_memory_access_unit_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // request channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic                                s_tuser,   // [0] cmd (0 read, 1 write)
    input  logic [emau_pkg::S_TDATA_BITS-1:0]   s_tdata,   // [1:0] access_size, [33:2] address,
                                                           // [97:34] write_data, [103:98] zero
    // result channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic                                m_tuser,   // [0] fault
    output logic [emau_pkg::M_TDATA_BITS-1:0]   m_tdata    // [63:0] read_data
);

    logic           q_valid;
    logic           q_pop;
    emau_pkg::req_t q_req;

    // front: fault check against null page and store end, word/offset split, queue
    emau_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tuser (s_tuser),
        .s_tdata (s_tdata),
        .q_valid (q_valid),
        .q_req   (q_req),
        .q_pop   (q_pop)
    );

    // back: reads both words, merges and writes back the bytes of a write, holds the result
    emau_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_req   (q_req),
        .q_pop   (q_pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tuser (m_tuser),
        .m_tdata (m_tdata)
    );

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the emulated memory access unit.
// Requests are byte, halfword, word or doubleword reads and writes at any
// byte address. A shadow copy of the word store predicts each result at the
// moment the request is accepted. Results are then matched in order against
// that prediction. The bench tracks which bytes have been written and never
// lets a request read a byte that has not been written yet.

module tb_top;

    // access size codes, log2 of the byte count
    localparam logic [1:0] SIZE_BYTE  = 2'd0;
    localparam logic [1:0] SIZE_HALF  = 2'd1;
    localparam logic [1:0] SIZE_WORD  = 2'd2;
    localparam logic [1:0] SIZE_DWORD = 2'd3;

    localparam int unsigned MEM_TOP      = 1 << emau_pkg::MEM_ADDR_BITS;  // first byte past the store
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          SETTLE       = 20;                  // a few back-end passes
    localparam int          PHASE_ITEMS  = 500;
    localparam int          LONG_HOLD    = 400;

    typedef struct packed {
        logic [63:0] read_data;
        logic        fault;
    } access_result_t;

    // Shadow store plus an in-order queue of the expected results
    class access_checker;
        logic [63:0]    shadow_words [emau_pkg::WORD_COUNT];
        access_result_t expected_results [$];
        int             mismatches;

        function new();
            foreach (shadow_words[i]) shadow_words[i] = '0;
            mismatches = 0;
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10) $display("MISMATCH: %s", msg);
        endfunction

        // an accepted request: update the shadow and queue its result
        function void note_request(logic cmd, logic [emau_pkg::S_TDATA_BITS-1:0] tdata);
            logic [1:0]     size;
            logic [31:0]    addr;
            logic [63:0]    wdata;
            logic [63:0]    end_addr;
            int unsigned    count;
            int unsigned    a;
            access_result_t res;
            size     = tdata[1:0];
            addr     = tdata[33:2];
            wdata    = tdata[97:34];
            count    = 1 << size;
            end_addr = {32'b0, addr} + 64'(count);
            res      = '0;
            if (addr < emau_pkg::PAGE_LIMIT || end_addr > 64'(emau_pkg::MEM_BYTES)) begin
                res.fault = 1'b1;
            end else begin
                for (int i = 0; i < count; i++) begin
                    a = addr + i;
                    if (cmd == emau_pkg::CMD_WRITE)
                        shadow_words[a[15:3]][8*a[2:0] +: 8] = wdata[8*i +: 8];
                    else
                        res.read_data[8*i +: 8] = shadow_words[a[15:3]][8*a[2:0] +: 8];
                end
            end
            expected_results.push_back(res);
        endfunction

        function void check_result(logic fault, logic [emau_pkg::M_TDATA_BITS-1:0] tdata);
            access_result_t want;
            if (expected_results.size() == 0) begin
                report($sformatf("result with nothing outstanding: fault %0b data %h",
                                 fault, tdata));
                return;
            end
            want = expected_results.pop_front();
            if (fault !== want.fault || tdata !== want.read_data)
                report($sformatf("fault exp %0b got %0b, read_data exp %h got %h",
                                 want.fault, fault, want.read_data, tdata));
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                              aclk;
    logic                              aresetn;
    logic                              s_tvalid;
    logic                              s_tready;
    logic                              s_tuser;
    logic [emau_pkg::S_TDATA_BITS-1:0] s_tdata;
    logic                              m_tvalid;
    logic                              m_tready;
    logic                              m_tuser;
    logic [emau_pkg::M_TDATA_BITS-1:0] m_tdata;

    access_checker checker_h = new();

    // stimulus-side record of written bytes, so that no read touches a blank one
    bit          byte_written [MEM_TOP];
    int unsigned recent_writes [$];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int          hold_left      = 0;
    int          cycle_count    = 0;

    emulated_memory_access_unit_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Both monitors see the pre-edge values, so ordering within the step
    // does not matter. Requests and results are FIFO-ordered through the checker.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            checker_h.note_request(s_tuser, s_tdata);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            checker_h.check_result(m_tuser, m_tdata);
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, checker_h.pending());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    // The hold-off fills the block's queue and backs up the request side.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Offer one request and hold it until accepted, then idle at random.
    // A read of any unwritten byte is turned into a write of the same bytes.
    task automatic issue(input logic cmd, input logic [1:0] size,
                         input logic [31:0] addr, input logic [63:0] data);
        int unsigned count;
        logic [63:0] end_addr;
        logic [31:0] a;
        bit          all_written;
        count    = 1 << size;
        end_addr = {32'b0, addr} + 64'(count);
        if (addr >= emau_pkg::PAGE_LIMIT && end_addr <= 64'(MEM_TOP)) begin
            all_written = 1'b1;
            for (int i = 0; i < count; i++) begin
                a = addr + 32'(i);
                if (!byte_written[a[emau_pkg::MEM_ADDR_BITS-1:0]]) all_written = 1'b0;
            end
            if (cmd == emau_pkg::CMD_READ && !all_written) cmd = emau_pkg::CMD_WRITE;
            if (cmd == emau_pkg::CMD_WRITE) begin
                for (int i = 0; i < count; i++) begin
                    a = addr + 32'(i);
                    byte_written[a[emau_pkg::MEM_ADDR_BITS-1:0]] = 1'b1;
                end
                recent_writes.push_back(addr);
                if (recent_writes.size() > 16) void'(recent_writes.pop_front());
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {6'b0, data, addr, size};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    // Stop offering and wait until every outstanding request has answered
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (checker_h.pending() != 0) @(posedge aclk);
    endtask

    // Mostly traffic in a small hot window and read-back of recent writes.
    // The rest covers the null page, the top of the store, the whole store and wild addresses.
    task automatic random_access();
        int unsigned pick;
        logic        cmd;
        logic [1:0]  size;
        logic [31:0] addr;
        logic [63:0] data;
        pick = $urandom_range(99);
        cmd  = logic'($urandom_range(1));
        size = 2'($urandom_range(3));
        data = {$urandom(), $urandom()};
        if (pick < 5)
            addr = $urandom_range(emau_pkg::PAGE_BYTES - 1);
        else if (pick < 10)
            addr = $urandom();
        else if (pick < 14)
            addr = MEM_TOP - $urandom_range(1, 8);
        else if (pick < 26)
            addr = $urandom_range(emau_pkg::PAGE_BYTES, MEM_TOP - 1);
        else if (pick < 60 && recent_writes.size() != 0) begin
            addr = recent_writes[$urandom_range(recent_writes.size() - 1)]
                   + $urandom_range(7);
            cmd  = emau_pkg::CMD_READ;
        end else
            addr = emau_pkg::PAGE_BYTES + $urandom_range(511);
        issue(cmd, size, addr, data);
    endtask

    task automatic run_phase(input int unsigned s_idle, input int unsigned r_stall,
                             input bit long_hold);
        send_idle_pct  = s_idle;
        recv_stall_pct = r_stall;
        if (long_hold) hold_left = LONG_HOLD;
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            random_access();
            // one mid-phase pause until the block has gone quiet
            if (i == PHASE_ITEMS / 2) drain();
        end
        drain();
    endtask

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= emau_pkg::CMD_READ;
        s_tdata  <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: first valid address, boundaries, straddles, faults
        issue(emau_pkg::CMD_WRITE, SIZE_DWORD, emau_pkg::PAGE_BYTES,     64'hFFFF_FFFF_FFFF_FFFF);
        issue(emau_pkg::CMD_WRITE, SIZE_DWORD, emau_pkg::PAGE_BYTES + 8, 64'h0);
        issue(emau_pkg::CMD_READ,  SIZE_DWORD, emau_pkg::PAGE_BYTES,     64'h0);
        issue(emau_pkg::CMD_READ,  SIZE_BYTE,  emau_pkg::PAGE_BYTES,     64'h0);
        // straddles the null page edge: must fault and leave the store alone
        issue(emau_pkg::CMD_WRITE, SIZE_HALF,  emau_pkg::PAGE_BYTES - 1, 64'h0);
        issue(emau_pkg::CMD_READ,  SIZE_HALF,  emau_pkg::PAGE_BYTES,     64'h0);
        issue(emau_pkg::CMD_WRITE, SIZE_BYTE,  emau_pkg::PAGE_BYTES + 7, 64'h5A);
        issue(emau_pkg::CMD_WRITE, SIZE_WORD,  emau_pkg::PAGE_BYTES + 5, 64'hFFFF_FFFF_1122_3344);
        issue(emau_pkg::CMD_READ,  SIZE_DWORD, emau_pkg::PAGE_BYTES + 4, 64'h0);
        issue(emau_pkg::CMD_WRITE, SIZE_DWORD, emau_pkg::PAGE_BYTES + 3, 64'h0123_4567_89AB_CDEF);
        issue(emau_pkg::CMD_READ,  SIZE_DWORD, emau_pkg::PAGE_BYTES + 3, 64'h0);
        issue(emau_pkg::CMD_READ,  SIZE_HALF,  emau_pkg::PAGE_BYTES + 7, 64'h0);
        issue(emau_pkg::CMD_READ,  SIZE_WORD,  emau_pkg::PAGE_BYTES + 2, 64'h0);
        // top of the store
        issue(emau_pkg::CMD_WRITE, SIZE_DWORD, MEM_TOP - 8,    64'hFFFF_FFFF_FFFF_FFFF);
        issue(emau_pkg::CMD_READ,  SIZE_BYTE,  MEM_TOP - 1,    64'h0);
        issue(emau_pkg::CMD_READ,  SIZE_DWORD, MEM_TOP - 8,    64'h0);
        issue(emau_pkg::CMD_WRITE, SIZE_DWORD, MEM_TOP - 7,    64'h0);
        issue(emau_pkg::CMD_READ,  SIZE_WORD,  MEM_TOP - 3,    64'h0);
        issue(emau_pkg::CMD_READ,  SIZE_BYTE,  MEM_TOP,        64'h0);
        issue(emau_pkg::CMD_WRITE, SIZE_DWORD, 32'h0,          64'hFFFF_FFFF_FFFF_FFFF);
        issue(emau_pkg::CMD_READ,  SIZE_BYTE,  32'h0,          64'h0);
        // no wrap past the top of the address space
        issue(emau_pkg::CMD_READ,  SIZE_DWORD, 32'hFFFF_FFF8,  64'h0);
        issue(emau_pkg::CMD_WRITE, SIZE_DWORD, 32'hFFFF_FFFF,  64'h0);
        issue(emau_pkg::CMD_READ,  SIZE_DWORD, MEM_TOP - 8,    64'h0);
        drain();

        // random phases: free-running with a long result hold-off, then
        // sender gaps, receiver stalls, and both together
        run_phase(0,  0,  1'b1);
        run_phase(50, 0,  1'b0);
        run_phase(0,  50, 1'b0);
        run_phase(20, 20, 1'b0);

        repeat (SETTLE) @(posedge aclk);
        if (checker_h.pending() != 0)
            checker_h.report($sformatf("%0d results never arrived", checker_h.pending()));
        if (checker_h.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: emulated_memory_access_unit_top.f
hw/rtl/emau_pkg.sv
hw/rtl/emau_ram.sv
hw/rtl/emau_front.sv
hw/rtl/emau_back.sv
hw/rtl/emulated_memory_access_unit_top.sv
tb/sv/tb_top.sv
